### rtl/wits_pkg.sv
// Shared types, constants and helpers of the waypoint interpolator.
package wits_pkg;

  // Field and datapath widths.
  localparam int POS_W     = 32;
  localparam int DELTA_W   = 33;
  localparam int STEP_W    = 24;
  localparam int EFF_W     = 25;
  localparam int TOT_W     = 26;
  localparam int K_W       = 5;
  localparam int MS_W      = 31;
  localparam int CFG_W     = 31;
  localparam int TAP_W     = K_W + 1;
  localparam int KSQ_W     = 2 * K_W;
  localparam int PROD_W    = DELTA_W + EFF_W;
  localparam int ACC_W     = 44;
  localparam int WIDE_W    = 64;
  localparam int MC_W      = $clog2(EFF_W);
  localparam int TDVD_W    = DELTA_W + 1;
  localparam int CNT_OUT_W = 5;
  localparam int NUM_POS   = 6;

  // Default geometry.
  localparam int DEF_JOINTS      = 6;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_MAX_WINDOW  = 32;

  localparam logic [STEP_W-1:0] STEP_SAT = 24'hFF_FFFF;
  localparam logic signed [WIDE_W-1:0] POS_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] POS_MIN = -64'sh0000_0000_8000_0000;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_SETPOS = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [0:0] {
    CFG_HALF_LEN = 1'b0,
    CFG_MAX_STEP = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_SETPOS,
    LOP_CLEAR,
    LOP_DELTA,
    LOP_PREFILL,
    LOP_STEP,
    LOP_FINISH
  } lane_op_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_D1GO,
    L_DIV1,
    L_MAC,
    L_D2GO,
    L_DIV2
  } lane_st_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_DELTA,
    T_DIVS,
    T_DIVW,
    T_STEP,
    T_WAIT,
    T_EMIT
  } top_st_t;

  // Command from the sequencer to every lane.
  typedef struct packed {
    lane_op_t          op;
    logic [EFF_W-1:0]  n;
    logic              linear;
    logic [STEP_W-1:0] steps;
    logic [K_W-1:0]    k;
  } lane_ctrl_t;

  // Status returned by one lane.
  typedef struct packed {
    logic                    done;
    logic signed [POS_W-1:0] start;
    logic [DELTA_W-1:0]      absd;
    logic signed [POS_W-1:0] cmd;
  } lane_stat_t;

  // Saturate a wide signed value to a signed 32-bit position.
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v > POS_MAX) begin
      return 32'sh7FFF_FFFF;
    end else if (v < POS_MIN) begin
      return 32'sh8000_0000;
    end else begin
      return signed'(v[POS_W-1:0]);
    end
  endfunction

endpackage

### rtl/wits_div.sv
// Restoring divider that produces one quotient bit per cycle.
module wits_div #(
  parameter int N = 58,
  parameter int D = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);
  localparam int CW = $clog2(N + 1);

  logic [D-1:0]  rem_r, rem_nxt;
  logic [N-1:0]  quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [D:0]    trial;

  // One shift and trial subtract per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[N-1]};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = D'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[N-2:0], 1'b1};
      end else begin
        rem_nxt = trial[D-1:0];
        quo_nxt = {quo_r[N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(N - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/wits_lane.sv
// One joint lane: segment state, sample window, interpolation and weighted sum.
module wits_lane #(
  parameter int MAX_WINDOW = wits_pkg::DEF_MAX_WINDOW
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wits_pkg::lane_ctrl_t             ctrl,
  input  logic signed [wits_pkg::POS_W-1:0] pos,
  output wits_pkg::lane_stat_t             stat
);
  import wits_pkg::*;

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic signed [POS_W-1:0]   win_r [MAX_WINDOW];
  logic signed [POS_W-1:0]   win_nxt [MAX_WINDOW];
  logic signed [POS_W-1:0]   start_r, start_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic [DELTA_W-1:0]        absd_r, absd_nxt;
  logic signed [POS_W-1:0]   cmd_r, cmd_nxt;
  logic                      done_r, done_nxt;
  lane_st_t                  st_r, st_nxt;
  logic [PROD_W-1:0]         mcand_r, mcand_nxt;
  logic [EFF_W-1:0]          mpl_r, mpl_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic [MC_W-1:0]           mcnt_r, mcnt_nxt;
  logic [TAP_W-1:0]          tap_r, tap_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      neg_r, neg_nxt;

  logic [TAP_W-1:0]          m_w, t1, mt, w;
  logic [KSQ_W-1:0]          ksq;
  logic [IDX_W-1:0]          idx;
  logic signed [POS_W-1:0]   samp;
  logic signed [POS_W+TAP_W:0] mac_p;
  logic [ACC_W-1:0]          acc_abs;
  logic signed [DELTA_W-1:0] d_v;
  logic signed [WIDE_W-1:0]  qs_v;
  logic                      shift_en, fill_en;
  logic signed [POS_W-1:0]   shift_val, fill_val;

  logic                      div_start, div_done;
  logic [PROD_W-1:0]         div_dvd, div_q;
  logic [STEP_W-1:0]         div_dvs;

  // Tap address and triangular weight of the current tap.
  always_comb begin
    m_w     = TAP_W'({ctrl.k, 1'b0}) - 1'b1;
    ksq     = KSQ_W'(ctrl.k) * KSQ_W'(ctrl.k);
    idx     = IDX_W'(MAX_WINDOW - int'(m_w) + int'(tap_r));
    t1      = tap_r + 1'b1;
    mt      = m_w - tap_r;
    w       = (t1 < mt) ? t1 : mt;
    samp    = win_r[idx];
    mac_p   = samp * signed'({1'b0, w});
    acc_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  end

  // The shared divider serves the sample quotient and the final scaling.
  // The divisor must stay put for the whole division.
  assign div_dvd = (st_r == L_D1GO) ? prod_r : PROD_W'(acc_abs);
  assign div_dvs = ((st_r == L_D1GO) || (st_r == L_DIV1)) ? ctrl.steps : STEP_W'(ksq);

  wits_div #(.N(PROD_W), .D(STEP_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Lane sequencer.
  always_comb begin
    start_nxt = start_r;
    delta_nxt = delta_r;
    absd_nxt  = absd_r;
    cmd_nxt   = cmd_r;
    done_nxt  = 1'b0;
    st_nxt    = st_r;
    mcand_nxt = mcand_r;
    mpl_nxt   = mpl_r;
    prod_nxt  = prod_r;
    mcnt_nxt  = mcnt_r;
    tap_nxt   = tap_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    div_start = 1'b0;
    shift_en  = 1'b0;
    shift_val = '0;
    fill_en   = 1'b0;
    fill_val  = '0;
    d_v       = DELTA_W'(pos) - DELTA_W'(start_r);
    qs_v      = '0;
    case (st_r)
      L_IDLE: begin
        case (ctrl.op)
          LOP_SETPOS: begin
            start_nxt = pos;
            fill_en   = 1'b1;
            fill_val  = pos;
          end
          LOP_CLEAR: begin
            start_nxt = '0;
            delta_nxt = '0;
            absd_nxt  = '0;
            fill_en   = 1'b1;
            fill_val  = '0;
          end
          LOP_DELTA: begin
            delta_nxt = d_v;
            absd_nxt  = d_v[DELTA_W-1] ? DELTA_W'(-d_v) : DELTA_W'(d_v);
          end
          LOP_PREFILL: begin
            fill_en  = 1'b1;
            fill_val = start_r;
          end
          LOP_FINISH: begin
            start_nxt = sat32(WIDE_W'(start_r) + WIDE_W'(delta_r));
          end
          LOP_STEP: begin
            neg_nxt = delta_r[DELTA_W-1];
            if (ctrl.linear) begin
              mcand_nxt = PROD_W'(absd_r);
              mpl_nxt   = ctrl.n;
              prod_nxt  = '0;
              mcnt_nxt  = '0;
              st_nxt    = L_MUL;
            end else begin
              shift_en  = 1'b1;
              shift_val = sat32(WIDE_W'(start_r) + WIDE_W'(delta_r));
              tap_nxt   = '0;
              acc_nxt   = '0;
              st_nxt    = L_MAC;
            end
          end
          default: begin
          end
        endcase
      end
      // Shift-and-add product of the delta magnitude and the step number.
      L_MUL: begin
        if (mpl_r[0]) begin
          prod_nxt = prod_r + mcand_r;
        end
        mcand_nxt = {mcand_r[PROD_W-2:0], 1'b0};
        mpl_nxt   = {1'b0, mpl_r[EFF_W-1:1]};
        mcnt_nxt  = mcnt_r + 1'b1;
        if (mcnt_r == MC_W'(EFF_W - 1)) begin
          st_nxt = L_D1GO;
        end
      end
      L_D1GO: begin
        div_start = 1'b1;
        st_nxt    = L_DIV1;
      end
      // The quotient with the delta's sign gives the new sample.
      L_DIV1: begin
        if (div_done) begin
          qs_v      = neg_r ? -signed'(WIDE_W'(div_q)) : signed'(WIDE_W'(div_q));
          shift_en  = 1'b1;
          shift_val = sat32(WIDE_W'(start_r) + qs_v);
          tap_nxt   = '0;
          acc_nxt   = '0;
          st_nxt    = L_MAC;
        end
      end
      // One weighted tap per cycle.
      L_MAC: begin
        acc_nxt = acc_r + ACC_W'(mac_p);
        tap_nxt = tap_r + 1'b1;
        if (tap_r == m_w - 1'b1) begin
          st_nxt = L_D2GO;
        end
      end
      L_D2GO: begin
        div_start = 1'b1;
        neg_nxt   = acc_r[ACC_W-1];
        st_nxt    = L_DIV2;
      end
      // Scale by k squared, truncating toward zero.
      L_DIV2: begin
        if (div_done) begin
          qs_v     = neg_r ? -signed'(WIDE_W'(div_q)) : signed'(WIDE_W'(div_q));
          cmd_nxt  = sat32(qs_v);
          done_nxt = 1'b1;
          st_nxt   = L_IDLE;
        end
      end
      default: begin
        st_nxt = L_IDLE;
      end
    endcase
  end

  // Window update: whole fill or one-sample shift.
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (fill_en) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        win_nxt[i] = fill_val;
      end
    end else if (shift_en) begin
      for (int i = 0; i < MAX_WINDOW - 1; i++) begin
        win_nxt[i] = win_r[i + 1];
      end
      win_nxt[MAX_WINDOW-1] = shift_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= L_IDLE;
      done_r  <= 1'b0;
      start_r <= '0;
      delta_r <= '0;
      absd_r  <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      st_r    <= st_nxt;
      done_r  <= done_nxt;
      start_r <= start_nxt;
      delta_r <= delta_nxt;
      absd_r  <= absd_nxt;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
    cmd_r   <= cmd_nxt;
    mcand_r <= mcand_nxt;
    mpl_r   <= mpl_nxt;
    prod_r  <= prod_nxt;
    mcnt_r  <= mcnt_nxt;
    tap_r   <= tap_nxt;
    acc_r   <= acc_nxt;
    neg_r   <= neg_nxt;
  end

  assign stat.done  = done_r;
  assign stat.start = start_r;
  assign stat.absd  = absd_r;
  assign stat.cmd   = cmd_r;

endmodule

### rtl/waypoint_interpolator_triangle_smooth_unit.sv
// Top level: waypoint queue, segment sequencer, joint lanes and result merge.
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_stall    opcode, pos_0..pos_5, stop_here
//  out_     output     out_valid / out_stall  cmd_0..cmd_5, accepted, segment_done,
//                                             busy_res, queue_count
//  cfg_     input      cfg_we                 cfg_index, cfg_data
//
// An active tick on the ramp runs the shift-add multiplier, a lane divider pass for the
// sample, the m-tap weighted sum and a second divider pass for the scaling; on the
// constant tail it runs only the weighted sum and the scaling pass. Starting a segment
// also runs the step divider.
// Reset is synchronous and needs no clearing pass. The input is taken only when the
// sequencer is idle; a finished word waits in the output register while the next
// input word is taken.
module waypoint_interpolator_triangle_smooth_unit #(
  parameter int JOINTS      = wits_pkg::DEF_JOINTS,
  parameter int QUEUE_DEPTH = wits_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_WINDOW  = wits_pkg::DEF_MAX_WINDOW
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_opcode,
  input  logic signed [wits_pkg::POS_W-1:0]  in_pos_0,
  input  logic signed [wits_pkg::POS_W-1:0]  in_pos_1,
  input  logic signed [wits_pkg::POS_W-1:0]  in_pos_2,
  input  logic signed [wits_pkg::POS_W-1:0]  in_pos_3,
  input  logic signed [wits_pkg::POS_W-1:0]  in_pos_4,
  input  logic signed [wits_pkg::POS_W-1:0]  in_pos_5,
  input  logic                               in_stop_here,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [wits_pkg::POS_W-1:0]  out_cmd_0,
  output logic signed [wits_pkg::POS_W-1:0]  out_cmd_1,
  output logic signed [wits_pkg::POS_W-1:0]  out_cmd_2,
  output logic signed [wits_pkg::POS_W-1:0]  out_cmd_3,
  output logic signed [wits_pkg::POS_W-1:0]  out_cmd_4,
  output logic signed [wits_pkg::POS_W-1:0]  out_cmd_5,
  output logic                               out_accepted,
  output logic                               out_segment_done,
  output logic                               out_busy_res,
  output logic [wits_pkg::CNT_OUT_W-1:0]     out_queue_count,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [wits_pkg::CFG_W-1:0]         cfg_data
);
  import wits_pkg::*;

  localparam int QA_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QE_W   = JOINTS * POS_W + 1;

  // Configuration registers.
  logic [K_W-1:0]  khalf_r;
  logic [MS_W-1:0] mstep_r;
  logic [K_W-1:0]  k0, keff;
  logic [TAP_W-1:0] m_top;
  logic [MS_W-1:0] ms_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      khalf_r <= K_W'(1);
      mstep_r <= MS_W'(65536);
    end else if (cfg_we) begin
      if (cfg_index == CFG_HALF_LEN) begin
        khalf_r <= cfg_data[K_W-1:0];
      end else if (cfg_index == CFG_MAX_STEP) begin
        mstep_r <= cfg_data[MS_W-1:0];
      end
    end
  end

  // Effective window half length and step limit.
  always_comb begin
    k0     = (khalf_r == '0) ? K_W'(1) : khalf_r;
    keff   = (int'(k0) > MAX_WINDOW / 2) ? K_W'(MAX_WINDOW / 2) : k0;
    m_top  = TAP_W'({keff, 1'b0}) - 1'b1;
    ms_eff = (mstep_r == '0) ? MS_W'(1) : mstep_r;
  end

  logic signed [POS_W-1:0] in_pos_a [NUM_POS];
  assign in_pos_a[0] = in_pos_0;
  assign in_pos_a[1] = in_pos_1;
  assign in_pos_a[2] = in_pos_2;
  assign in_pos_a[3] = in_pos_3;
  assign in_pos_a[4] = in_pos_4;
  assign in_pos_a[5] = in_pos_5;

  // Sequencer state.
  top_st_t           st_r, st_nxt;
  logic              idle_r, idle_nxt;
  logic              first_r, first_nxt;
  logic              stop_r, stop_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [EFF_W-1:0]  eff_r, eff_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [TOT_W-1:0]  sidx_r, sidx_nxt;
  logic [TOT_W-1:0]  sidx_inc;
  logic [QA_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              push_we;

  // Result being assembled and the output register.
  logic signed [POS_W-1:0] res_cmd_r [NUM_POS];
  logic signed [POS_W-1:0] res_cmd_nxt [NUM_POS];
  logic                    res_acc_r, res_acc_nxt, res_done_r, res_done_nxt;
  logic                    out_valid_r, out_valid_nxt, out_load;
  logic signed [POS_W-1:0] out_cmd_r [NUM_POS];
  logic                    out_acc_r, out_done_r, out_busy_r;
  logic [CNT_OUT_W-1:0]    out_cnt_r;

  // Waypoint memory with registered read at the head.
  logic [QE_W-1:0] q_mem [QUEUE_DEPTH];
  logic [QE_W-1:0] rd_q_r;
  logic [QE_W-1:0] wr_word;

  always_comb begin
    wr_word = '0;
    for (int j = 0; j < JOINTS; j++) begin
      wr_word[j*POS_W +: POS_W] = in_pos_a[j];
    end
    wr_word[QE_W-1] = in_stop_here;
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      q_mem[tail_r] <= wr_word;
    end
    rd_q_r <= q_mem[head_r];
  end

  // Lanes.
  lane_ctrl_t              lctrl;
  lane_stat_t              lstat [JOINTS];
  logic signed [POS_W-1:0] lane_pos [JOINTS];
  logic [JOINTS-1:0]       lane_done_v;
  logic [DELTA_W-1:0]      maxd;

  for (genvar g = 0; g < JOINTS; g++) begin : g_lane
    assign lane_pos[g] = (st_r == T_DELTA) ? signed'(rd_q_r[g*POS_W +: POS_W]) : in_pos_a[g];
    assign lane_done_v[g] = lstat[g].done;
    wits_lane #(.MAX_WINDOW(MAX_WINDOW)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lctrl),
      .pos   (lane_pos[g]),
      .stat  (lstat[g])
    );
  end

  // Largest joint move of the new segment.
  always_comb begin
    maxd = '0;
    for (int j = 0; j < JOINTS; j++) begin
      if (lstat[j].absd > maxd) begin
        maxd = lstat[j].absd;
      end
    end
  end

  // Step count divider: ceil(max move / step limit).
  logic              sdiv_start, sdiv_done;
  logic [TDVD_W-1:0] sdiv_dvd, sdiv_q;
  logic [STEP_W-1:0] steps_v;
  logic [EFF_W-1:0]  eff_v;

  assign sdiv_dvd = TDVD_W'(maxd) + TDVD_W'(ms_eff) - TDVD_W'(1);

  wits_div #(.N(TDVD_W), .D(MS_W)) u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sdiv_start),
    .dividend (sdiv_dvd),
    .divisor  (ms_eff),
    .done     (sdiv_done),
    .quotient (sdiv_q)
  );

  always_comb begin
    if (sdiv_q == '0) begin
      steps_v = STEP_W'(1);
    end else if (sdiv_q > TDVD_W'(STEP_SAT)) begin
      steps_v = STEP_SAT;
    end else begin
      steps_v = sdiv_q[STEP_W-1:0];
    end
    eff_v = EFF_W'(steps_v) + EFF_W'(first_r);
  end

  assign in_stall = (st_r != T_IDLE);
  assign sidx_inc = sidx_r + 1'b1;

  // Next state, lane commands and result assembly.
  always_comb begin
    st_nxt       = st_r;
    idle_nxt     = idle_r;
    first_nxt    = first_r;
    stop_nxt     = stop_r;
    steps_nxt    = steps_r;
    eff_nxt      = eff_r;
    total_nxt    = total_r;
    sidx_nxt     = sidx_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    fill_nxt     = fill_r;
    push_we      = 1'b0;
    sdiv_start   = 1'b0;
    res_acc_nxt  = res_acc_r;
    res_done_nxt = res_done_r;
    for (int j = 0; j < NUM_POS; j++) begin
      res_cmd_nxt[j] = res_cmd_r[j];
    end
    lctrl.op     = LOP_NONE;
    lctrl.n      = sidx_r[EFF_W-1:0];
    lctrl.linear = (sidx_r < {1'b0, eff_r});
    lctrl.steps  = steps_r;
    lctrl.k      = keff;
    out_load     = 1'b0;
    case (st_r)
      T_IDLE: begin
        if (in_valid) begin
          res_acc_nxt  = 1'b0;
          res_done_nxt = 1'b0;
          for (int j = 0; j < NUM_POS; j++) begin
            res_cmd_nxt[j] = '0;
          end
          case (opcode_t'(in_opcode))
            OP_TICK: begin
              if (idle_r && (fill_r != '0)) begin
                head_nxt = (head_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
                fill_nxt = fill_r - 1'b1;
                st_nxt   = T_DELTA;
              end else if (idle_r) begin
                for (int j = 0; j < JOINTS; j++) begin
                  res_cmd_nxt[j] = lstat[j].start;
                end
                res_done_nxt = 1'b1;
                st_nxt       = T_EMIT;
              end else begin
                st_nxt = T_STEP;
              end
            end
            OP_PUSH: begin
              if (fill_r < FILL_W'(QUEUE_DEPTH)) begin
                push_we     = 1'b1;
                tail_nxt    = (tail_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
                fill_nxt    = fill_r + 1'b1;
                res_acc_nxt = 1'b1;
              end
              st_nxt = T_EMIT;
            end
            OP_SETPOS: begin
              lctrl.op = LOP_SETPOS;
              st_nxt   = T_EMIT;
            end
            OP_CLEAR: begin
              lctrl.op  = LOP_CLEAR;
              head_nxt  = '0;
              tail_nxt  = '0;
              fill_nxt  = '0;
              idle_nxt  = 1'b1;
              first_nxt = 1'b1;
              sidx_nxt  = '0;
              steps_nxt = STEP_W'(1);
              eff_nxt   = '0;
              total_nxt = '0;
              st_nxt    = T_EMIT;
            end
            default: begin
              st_nxt = T_EMIT;
            end
          endcase
        end
      end
      // Lanes take the delta toward the popped waypoint.
      T_DELTA: begin
        lctrl.op = LOP_DELTA;
        stop_nxt = rd_q_r[QE_W-1];
        st_nxt   = T_DIVS;
      end
      T_DIVS: begin
        sdiv_start = 1'b1;
        st_nxt     = T_DIVW;
      end
      // Segment lengths are set once the step count is known.
      T_DIVW: begin
        if (sdiv_done) begin
          steps_nxt = steps_v;
          eff_nxt   = eff_v;
          total_nxt = TOT_W'(eff_v) + (stop_r ? TOT_W'(m_top) : '0);
          if (first_r) begin
            lctrl.op  = LOP_PREFILL;
            first_nxt = 1'b0;
          end
          idle_nxt = 1'b0;
          sidx_nxt = '0;
          st_nxt   = T_STEP;
        end
      end
      T_STEP: begin
        lctrl.op = LOP_STEP;
        st_nxt   = T_WAIT;
      end
      // Merge the lane results and close the segment on its last step.
      T_WAIT: begin
        if (&lane_done_v) begin
          for (int j = 0; j < JOINTS; j++) begin
            res_cmd_nxt[j] = lstat[j].cmd;
          end
          sidx_nxt = sidx_inc;
          if (sidx_inc >= total_r) begin
            idle_nxt     = 1'b1;
            lctrl.op     = LOP_FINISH;
            res_done_nxt = 1'b1;
          end
          st_nxt = T_EMIT;
        end
      end
      T_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          st_nxt   = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt = out_load;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      idle_r      <= 1'b1;
      first_r     <= 1'b1;
      stop_r      <= 1'b0;
      steps_r     <= STEP_W'(1);
      eff_r       <= '0;
      total_r     <= '0;
      sidx_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      idle_r      <= idle_nxt;
      first_r     <= first_nxt;
      stop_r      <= stop_nxt;
      steps_r     <= steps_nxt;
      eff_r       <= eff_nxt;
      total_r     <= total_nxt;
      sidx_r      <= sidx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_acc_r  <= res_acc_nxt;
    res_done_r <= res_done_nxt;
    for (int j = 0; j < NUM_POS; j++) begin
      res_cmd_r[j] <= res_cmd_nxt[j];
    end
    if (out_load) begin
      for (int j = 0; j < NUM_POS; j++) begin
        out_cmd_r[j] <= res_cmd_r[j];
      end
      out_acc_r  <= res_acc_r;
      out_done_r <= res_done_r;
      out_busy_r <= (fill_r != '0) || !idle_r;
      out_cnt_r  <= CNT_OUT_W'(fill_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cmd_0        = out_cmd_r[0];
  assign out_cmd_1        = out_cmd_r[1];
  assign out_cmd_2        = out_cmd_r[2];
  assign out_cmd_3        = out_cmd_r[3];
  assign out_cmd_4        = out_cmd_r[4];
  assign out_cmd_5        = out_cmd_r[5];
  assign out_accepted     = out_acc_r;
  assign out_segment_done = out_done_r;
  assign out_busy_res     = out_busy_r;
  assign out_queue_count  = out_cnt_r;

  // The queue never holds more than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  // An empty queue has equal pointers.
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with unequal pointers");

  // Lanes run in lockstep and finish together.
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done_v != '0) |-> (&lane_done_v))
    else $error("lanes finished out of step");

  // An open segment always has steps left when waiting for a word.
  a_steps_left: assert property (@(posedge clk) disable iff (!rst_n)
    (!idle_r && (st_r == T_IDLE)) |-> (sidx_r < total_r))
    else $error("open segment without steps left");

endmodule
